### rtl/spq_pkg.sv
// shared types, constants and helpers for the sortable packet queue
`default_nettype none

package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = 5;
  localparam int KEY_W   = 16;
  localparam int DEST_W  = 16;
  localparam int PAY_W   = 32;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_SORT   = 2'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DEST_W-1:0] dest;
    logic [PAY_W-1:0]  payload;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    entry_t          data;
  } cmd_t;

  // queue position to storage slot, slot of position 0 is head
  function automatic logic [PTR_W-1:0] pos2slot(input logic [PTR_W-1:0] head,
                                               input logic [PTR_W-1:0] pos);
    logic [PTR_W:0] s;
    s = {1'b0, head} + {1'b0, pos};
    if (s >= (PTR_W + 1)'(DEPTH)) s = s - (PTR_W + 1)'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/spq_front.sv
// front end: accepts command transactions into a short command queue
`default_nettype none

module spq_front import spq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   command,
  input  wire logic [KEY_W-1:0]  sort_key,
  input  wire logic [DEST_W-1:0] dest_tag,
  input  wire logic [PAY_W-1:0]  payload,
  output logic                   cmd_valid,
  output cmd_t                   cmd,
  input  wire logic              cmd_take
);

  cmd_t              slot [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;
  cmd_t              incoming;

  assign in_stall  = (fill == QCNT_W'(QDEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = slot[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_valid && cmd_take;

  always_comb begin
    incoming.op           = command;
    incoming.data.key     = sort_key;
    incoming.data.dest    = dest_tag;
    incoming.data.payload = payload;
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= incoming;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      if (push && !pop)      fill <= fill + QCNT_W'(1);
      else if (pop && !push) fill <= fill - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/spq_back.sv
// back end: entry store, command sequencer and result register
`default_nettype none

module spq_back import spq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire cmd_t               cmd,
  output logic                    cmd_take,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [KEY_W-1:0]        out_key,
  output logic [DEST_W-1:0]       out_dest,
  output logic [PAY_W-1:0]        out_payload,
  output logic [ST_W-1:0]         status,
  output logic [ENTRY_W-1:0]      entry_count
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_POP_WAIT = 4'd1;
  localparam logic [3:0] S_SRCH_RD  = 4'd2;
  localparam logic [3:0] S_SRCH_CHK = 4'd3;
  localparam logic [3:0] S_SORT_LD  = 4'd4;
  localparam logic [3:0] S_SORT_LDW = 4'd5;
  localparam logic [3:0] S_SORT_RD  = 4'd6;
  localparam logic [3:0] S_SORT_CMP = 4'd7;
  localparam logic [3:0] S_SORT_WB  = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  entry_t            mem [DEPTH];
  entry_t            rd_data;
  logic [PTR_W-1:0]  rd_addr;
  logic [PTR_W-1:0]  rd_pos;
  logic              we;
  logic [PTR_W-1:0]  wa;
  entry_t            wd;

  logic [3:0]        state;
  logic [PTR_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx_i;
  logic [CNT_W-1:0]  idx_j;
  logic [DEST_W-1:0] tag;
  entry_t            hold;
  entry_t            res;
  logic [ST_W-1:0]   res_status;

  logic              full;
  logic              empty;
  logic              swap;
  logic              out_free;
  logic [PTR_W-1:0]  new_head;
  logic [CNT_W-1:0]  last;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign last     = count - CNT_W'(1);
  assign new_head = (head == '0) ? PTR_W'(DEPTH - 1) : head - PTR_W'(1);
  assign swap     = (hold.key < rd_data.key);
  assign out_free = !out_valid || !out_stall;
  assign cmd_take = (state == S_IDLE) && cmd_valid;

  always_comb begin
    rd_pos = '0;
    we     = 1'b0;
    wa     = new_head;
    wd     = cmd.data;
    unique case (state)
      S_IDLE: begin
        rd_pos = last[PTR_W-1:0];
        we     = cmd_valid && (cmd.op == OP_PUSH) && !full;
      end
      S_SRCH_RD: rd_pos = idx_i[PTR_W-1:0];
      S_SORT_LD: rd_pos = idx_i[PTR_W-1:0];
      S_SORT_RD: rd_pos = idx_j[PTR_W-1:0];
      S_SORT_CMP: begin
        we = swap;
        wa = pos2slot(head, idx_j[PTR_W-1:0]);
        wd = hold;
      end
      S_SORT_WB: begin
        we = 1'b1;
        wa = pos2slot(head, idx_i[PTR_W-1:0]);
        wd = hold;
      end
      default: ;
    endcase
    rd_addr = pos2slot(head, rd_pos);
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            res        <= '0;
            res_status <= ST_OK;
            tag        <= cmd.data.dest;
            idx_i      <= '0;
            idx_j      <= '0;
            state      <= S_EMIT;
            case (cmd.op)
              OP_PUSH: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  head  <= new_head;
                  count <= count + CNT_W'(1);
                end
              end
              OP_POP: begin
                if (empty) res_status <= ST_EMPTY;
                else state <= S_POP_WAIT;
              end
              OP_SORT: begin
                if (empty) res_status <= ST_EMPTY;
                else state <= S_SORT_LD;
              end
              default: begin
                if (empty) res_status <= ST_NOTFOUND;
                else state <= S_SRCH_RD;
              end
            endcase
          end
        end
        S_POP_WAIT: begin
          res   <= rd_data;
          count <= last;
          state <= S_EMIT;
        end
        S_SRCH_RD: state <= S_SRCH_CHK;
        S_SRCH_CHK: begin
          if (rd_data.dest == tag) begin
            res   <= rd_data;
            state <= S_EMIT;
          end else if (idx_i + CNT_W'(1) == count) begin
            res_status <= ST_NOTFOUND;
            state      <= S_EMIT;
          end else begin
            idx_i <= idx_i + CNT_W'(1);
            state <= S_SRCH_RD;
          end
        end
        S_SORT_LD: state <= S_SORT_LDW;
        S_SORT_LDW: begin
          hold  <= rd_data;
          idx_j <= '0;
          state <= S_SORT_RD;
        end
        S_SORT_RD: begin
          if (idx_j == idx_i) begin
            idx_j <= idx_j + CNT_W'(1);
            if (idx_j + CNT_W'(1) == count) state <= S_SORT_WB;
          end else begin
            state <= S_SORT_CMP;
          end
        end
        S_SORT_CMP: begin
          if (swap) hold <= rd_data;
          idx_j <= idx_j + CNT_W'(1);
          state <= (idx_j + CNT_W'(1) == count) ? S_SORT_WB : S_SORT_RD;
        end
        S_SORT_WB: begin
          idx_i <= idx_i + CNT_W'(1);
          state <= (idx_i + CNT_W'(1) == count) ? S_EMIT : S_SORT_LD;
        end
        S_EMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= (state == S_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_key     <= res.key;
      out_dest    <= res.dest;
      out_payload <= res.payload;
      status      <= res_status;
      entry_count <= ENTRY_W'(count);
    end
  end

endmodule

`default_nettype wire

### rtl/sortable_packet_queue_unit.sv
// top level of the sortable packet queue
//
//   channel  | handshake           | fields
//   ---------+---------------------+-----------------------------------------------
//   input    | in_valid, in_stall  | command, sort_key, dest_tag, payload
//   output   | out_valid, out_stall| out_key, out_dest, out_payload, status,
//            |                     | entry_count
//
// pop, search and sort read the entries one at a time through the single read port
// of the entry store, search walking from position 0 and sort comparing every pair
// reset is synchronous and empties the queue, store contents are left as they are
// the input side holds two transactions while the engine works or the output stalls
// a result waits in the output register while the next command is processed
`default_nettype none

module sortable_packet_queue_unit import spq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [OP_W-1:0]    command,
  input  wire logic [KEY_W-1:0]   sort_key,
  input  wire logic [DEST_W-1:0]  dest_tag,
  input  wire logic [PAY_W-1:0]   payload,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [KEY_W-1:0]        out_key,
  output logic [DEST_W-1:0]       out_dest,
  output logic [PAY_W-1:0]        out_payload,
  output logic [ST_W-1:0]         status,
  output logic [ENTRY_W-1:0]      entry_count
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  spq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .sort_key  (sort_key),
    .dest_tag  (dest_tag),
    .payload   (payload),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  spq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_key     (out_key),
    .out_dest    (out_dest),
    .out_payload (out_payload),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

`default_nettype wire

### rtl/spq_checker.sv
// port level checks for the sortable packet queue, bound to the top level
`default_nettype none

module spq_assertions import spq_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [OP_W-1:0]    command,
  input wire logic [KEY_W-1:0]   sort_key,
  input wire logic [DEST_W-1:0]  dest_tag,
  input wire logic [PAY_W-1:0]   payload,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [KEY_W-1:0]   out_key,
  input wire logic [DEST_W-1:0]  out_dest,
  input wire logic [PAY_W-1:0]   out_payload,
  input wire logic [ST_W-1:0]    status,
  input wire logic [ENTRY_W-1:0] entry_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_key) && $stable(out_dest)
      && $stable(out_payload) && $stable(status) && $stable(entry_count))
    else $error("stalled result changed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= ENTRY_W'(DEPTH))
    else $error("entry count above depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == ENTRY_W'(DEPTH))
    else $error("full reported with room left");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> entry_count == '0)
    else $error("empty reported with entries held");

  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY || status == ST_NOTFOUND || status == ST_FULL)
      |-> out_key == '0 && out_dest == '0 && out_payload == '0)
    else $error("data on a result without an entry");

endmodule

bind sortable_packet_queue_unit spq_assertions u_spq_assertions (.*);

`default_nettype wire

### tb/spq_checker.sv
// checker for the sortable packet queue: tracks the queue, predicts and compares every result
module spq_checker import spq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [OP_W-1:0]    command,
  input  wire logic [KEY_W-1:0]   sort_key,
  input  wire logic [DEST_W-1:0]  dest_tag,
  input  wire logic [PAY_W-1:0]   payload,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [KEY_W-1:0]   out_key,
  input  wire logic [DEST_W-1:0]  out_dest,
  input  wire logic [PAY_W-1:0]   out_payload,
  input  wire logic [ST_W-1:0]    status,
  input  wire logic [ENTRY_W-1:0] entry_count,
  output int                      fails,
  output int                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DEST_W-1:0]  dest;
    logic [PAY_W-1:0]   payload;
    logic [ST_W-1:0]    st;
    logic [ENTRY_W-1:0] cnt;
  } result_t;

  entry_t  held_q [DEPTH];
  int      held_n;
  result_t awaited_q [$];
  result_t got;
  result_t want;
  entry_t  pushed;
  int      reported;

  initial begin
    fails = 0;
    outstanding = 0;
    held_n = 0;
    reported = 0;
  end

  function automatic result_t queue_step(input logic [OP_W-1:0] op, input entry_t item);
    result_t r;
    entry_t  tmp;
    int      i;
    int      j;
    r = '0;
    r.st = ST_OK;
    case (op)
      OP_PUSH: begin
        if (held_n >= DEPTH) begin
          r.st = ST_FULL;
        end else begin
          for (i = held_n; i > 0; i--) held_q[i] = held_q[i-1];
          held_q[0] = item;
          held_n++;
        end
      end
      OP_POP: begin
        if (held_n == 0) begin
          r.st = ST_EMPTY;
        end else begin
          held_n--;
          r.key = held_q[held_n].key;
          r.dest = held_q[held_n].dest;
          r.payload = held_q[held_n].payload;
        end
      end
      OP_SORT: begin
        if (held_n == 0) begin
          r.st = ST_EMPTY;
        end else begin
          for (i = 0; i < held_n; i++)
            for (j = 0; j < held_n; j++)
              if (held_q[i].key < held_q[j].key) begin
                tmp = held_q[i];
                held_q[i] = held_q[j];
                held_q[j] = tmp;
              end
        end
      end
      default: begin
        r.st = ST_NOTFOUND;
        for (i = 0; i < held_n; i++) begin
          if (held_q[i].dest == item.dest) begin
            r.key = held_q[i].key;
            r.dest = held_q[i].dest;
            r.payload = held_q[i].payload;
            r.st = ST_OK;
            break;
          end
        end
      end
    endcase
    r.cnt = ENTRY_W'(held_n);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_n = 0;
      awaited_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        pushed.key = sort_key;
        pushed.dest = dest_tag;
        pushed.payload = payload;
        awaited_q.push_back(queue_step(command, pushed));
      end
      if (out_valid && !out_stall) begin
        got.key = out_key;
        got.dest = out_dest;
        got.payload = out_payload;
        got.st = status;
        got.cnt = entry_count;
        if (awaited_q.size() == 0) begin
          fails++;
          if (reported < 10) begin
            reported++;
            $display("unexpected transaction: key %h dest %h payload %h status %0d count %0d",
                     got.key, got.dest, got.payload, got.st, got.cnt);
          end
        end else begin
          want = awaited_q.pop_front();
          if (got.key !== want.key || got.dest !== want.dest || got.payload !== want.payload
              || got.st !== want.st || got.cnt !== want.cnt) begin
            fails++;
            if (reported < 10) begin
              reported++;
              $display("mismatch: expected key %h dest %h payload %h status %0d count %0d",
                       want.key, want.dest, want.payload, want.st, want.cnt);
              $display("          got      key %h dest %h payload %h status %0d count %0d",
                       got.key, got.dest, got.payload, got.st, got.cnt);
            end
          end
        end
      end
    end
    outstanding <= awaited_q.size();
  end

endmodule

### tb/sortable_packet_queue_unit_tb.sv
// testbench top for the sortable packet queue: stimulus, receiver, watchdog and verdict
module sortable_packet_queue_unit_tb import spq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 380;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    command = OP_PUSH;
  logic [KEY_W-1:0]   sort_key = '0;
  logic [DEST_W-1:0]  dest_tag = '0;
  logic [PAY_W-1:0]   payload = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KEY_W-1:0]   out_key;
  logic [DEST_W-1:0]  out_dest;
  logic [PAY_W-1:0]   out_payload;
  logic [ST_W-1:0]    status;
  logic [ENTRY_W-1:0] entry_count;

  int                 fails;
  int                 outstanding;
  int                 send_idle = 0;
  int                 recv_idle = 0;
  bit                 hold_req = 1'b0;
  int                 quiet_cycles = 0;
  logic [DEST_W-1:0]  tag_pool [8];

  always #5 clk = ~clk;

  sortable_packet_queue_unit dut (
    .clk, .rst, .in_valid, .in_stall, .command, .sort_key, .dest_tag, .payload,
    .out_valid, .out_stall, .out_key, .out_dest, .out_payload, .status, .entry_count
  );

  spq_checker u_check (
    .clk, .rst, .in_valid, .in_stall, .command, .sort_key, .dest_tag, .payload,
    .out_valid, .out_stall, .out_key, .out_dest, .out_payload, .status, .entry_count,
    .fails, .outstanding
  );

  // receiver, with one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("sortable_packet_queue_unit_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                          input logic [DEST_W-1:0] d, input logic [PAY_W-1:0] p);
    in_valid <= 1'b1;
    command <= op;
    sort_key <= k;
    dest_tag <= d;
    payload <= p;
    do @(posedge clk); while (in_stall);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic random_item(input int push_pct);
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  k;
    logic [DEST_W-1:0] d;
    int                r;
    r = $urandom_range(99);
    if (r < push_pct) begin
      op = OP_PUSH;
    end else begin
      r = $urandom_range(99);
      op = (r < 45) ? OP_POP : (r < 70) ? OP_SORT : OP_SEARCH;
    end
    // small keys give ties in the sort, pooled tags give search hits
    k = ($urandom_range(3) == 0) ? KEY_W'($urandom_range(7)) : KEY_W'($urandom);
    d = ($urandom_range(9) < 7) ? tag_pool[$urandom_range(7)] : DEST_W'($urandom);
    send_cmd(op, k, d, $urandom);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic run_phase(input int n_items, input int s_idle, input int r_idle);
    int k;
    int push_pct;
    send_idle = s_idle;
    recv_idle = r_idle;
    push_pct = 50;
    for (k = 0; k < n_items; k++) begin
      if (k % 20 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 20;
        endcase
      end
      random_item(push_pct);
    end
    drain();
  endtask

  initial begin
    int i;
    for (i = 0; i < 8; i++) tag_pool[i] = DEST_W'($urandom);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty queue corner cases
    send_cmd(OP_POP, '1, '1, '1);
    send_cmd(OP_SORT, '1, '1, '1);
    send_cmd(OP_SEARCH, '0, '0, '0);
    // field extremes, search hit and miss, small sort
    send_cmd(OP_PUSH, '1, '1, '1);
    send_cmd(OP_PUSH, '0, '0, '0);
    send_cmd(OP_SEARCH, '0, '1, '0);
    send_cmd(OP_SEARCH, '0, 16'h5a5a, '0);
    send_cmd(OP_SORT, '0, '0, '0);
    // fill up with repeated keys, then full push, full sort
    for (i = 0; i < 14; i++)
      send_cmd(OP_PUSH, KEY_W'((i % 5) * 16'h3001), DEST_W'(i * 16'h1111), $urandom);
    send_cmd(OP_PUSH, 16'h7fff, 16'h8000, 32'h8000_0001);
    send_cmd(OP_SORT, '0, '0, '0);
    send_cmd(OP_SEARCH, '0, '0, '0);
    send_cmd(OP_POP, '0, '0, '0);
    drain();

    run_phase(PHASE_ITEMS, 8, 69);
    run_phase(PHASE_ITEMS, 69, 8);
    hold_req = 1'b1;
    run_phase(PHASE_ITEMS, 0, 0);

    in_valid <= 1'b0;
    repeat (50) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("sortable_packet_queue_unit_tb OK");
    end else begin
      $display("sortable_packet_queue_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
